@@ rtl/sstc_pkg.sv @@
package sstc_pkg;

   // ADC resolution; only the low AdcBits bits of a sample are used
   localparam int AdcBits = 16;
   localparam logic [15:0] AdcMask = 16'((32'd1 << AdcBits) - 32'd1);

   localparam logic [15:0] HystReset = 16'd5;
   localparam logic [15:0] WordOne   = 16'd1;

   // request codes
   localparam logic ActPoll   = 1'b0;
   localparam logic ActReport = 1'b1;

   // sticky event flag positions
   localparam int EvRise  = 0;
   localparam int EvFall  = 1;
   localparam int EvOn    = 2;
   localparam int EvOff   = 3;
   localparam int EvAdc   = 4;
   localparam int EvFirst = 5;
   localparam int EvCount = 6;

   typedef struct packed {
      logic        action;
      logic        read_ok;
      logic [15:0] out_word;
      logic [15:0] din_word;
      logic [15:0] adc_sample;
      logic [15:0] led_word;
   } req_type;

   typedef struct packed {
      logic        poll_ok;
      logic        out_state;
      logic        din_state;
      logic [15:0] adc_level;
      logic        led_state;
      logic        rise_event;
      logic        fall_event;
      logic        on_event;
      logic        off_event;
      logic        adc_event;
      logic        first_event;
      logic        any_event;
   } rsp_type;

endpackage

@@ rtl/switch_status_change_tracker_core.sv @@
// Switch status tracker. Each request word is either a poll (register values read from
// the switch device) or a report, and yields exactly one response word. A failed poll
// changes nothing; a successful one updates the output, input and LED bits and raises
// sticky events. When the ADC sample leaves the dead band around the stored level, the
// new level is the sample (zero hysteresis) or the sample rounded down to a multiple of
// the hysteresis, found by a bit-serial restoring remainder that takes one bit per cycle.
// Such a poll passes accept, 16 remainder steps, level update and response load; others
// go from accept to response load. A new request is accepted while the previous response
// still waits in the output register. Write csr_wr_data only while the block is idle.
module switch_status_change_tracker_core
   import sstc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StFin  = 2'd2;
   localparam logic [1:0] StDone = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [15:0]         hyst_ff;
   logic                out_bit_ff, out_bit_in;
   logic                din_bit_ff, din_bit_in;
   logic                led_bit_ff, led_bit_in;
   logic [15:0]         level_ff, level_in;
   logic [EvCount-1:0]  flags_ff, flags_in;
   logic                first_ff, first_in;
   logic                act_ff, act_in;
   logic                ok_ff, ok_in;
   logic [15:0]         sample_ff, sample_in;
   logic [15:0]         div_ff, div_in;
   logic [15:0]         rem_ff, rem_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [15:0] sample;
   logic        new_out, new_din, new_led;
   logic [16:0] upper_edge;
   logic        up_hit, dn_hit, adc_move;
   logic [16:0] rem_shift;
   logic [16:0] rem_diff;

   // decode the incoming poll and check the dead band
   assign sample     = req_data.adc_sample & AdcMask;
   assign new_out    = (req_data.out_word == WordOne);
   assign new_din    = (req_data.din_word == WordOne);
   assign new_led    = (req_data.led_word == WordOne);
   assign upper_edge = {1'b0, level_ff} + {1'b0, hyst_ff};
   assign up_hit     = ({1'b0, sample} >= upper_edge);
   assign dn_hit     = (level_ff >= hyst_ff) && (sample <= (level_ff - hyst_ff));
   assign adc_move   = up_hit || dn_hit;

   // one restoring remainder step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, div_ff[15]};
   assign rem_diff  = rem_shift - {1'b0, hyst_ff};

   always_comb begin
      state_in     = state_ff;
      out_bit_in   = out_bit_ff;
      din_bit_in   = din_bit_ff;
      led_bit_in   = led_bit_ff;
      level_in     = level_ff;
      flags_in     = flags_ff;
      first_in     = first_ff;
      act_in       = act_ff;
      ok_in        = ok_ff;
      sample_in    = sample_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               act_in   = req_data.action;
               ok_in    = req_data.read_ok;
               state_in = StDone;
               if ((req_data.action == ActPoll) && req_data.read_ok) begin
                  // update bits and raise edge events
                  if (din_bit_ff && !new_din) flags_in[EvFall] = 1'b1;
                  if (!din_bit_ff && new_din) flags_in[EvRise] = 1'b1;
                  if (out_bit_ff && !new_out) flags_in[EvOff] = 1'b1;
                  if (!out_bit_ff && new_out) flags_in[EvOn] = 1'b1;
                  out_bit_in = new_out;
                  din_bit_in = new_din;
                  led_bit_in = new_led;
                  if (first_ff) begin
                     flags_in[EvFirst] = 1'b1;
                     first_in          = 1'b0;
                  end
                  // start the remainder when the level moves
                  if (adc_move) begin
                     flags_in[EvAdc] = 1'b1;
                     if (hyst_ff == 16'd0) begin
                        level_in = sample;
                     end else begin
                        sample_in = sample;
                        div_in    = sample;
                        rem_in    = 16'd0;
                        cnt_in    = 4'd0;
                        state_in  = StDiv;
                     end
                  end
               end
            end
         end
         StDiv: begin
            // advance one remainder bit
            if (!rem_diff[16]) begin
               rem_in = rem_diff[15:0];
            end else begin
               rem_in = rem_shift[15:0];
            end
            div_in = {div_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = StFin;
            end
         end
         StFin: begin
            // round the sample down to a multiple of the hysteresis
            level_in = sample_ff - rem_ff;
            state_in = StDone;
         end
         StDone: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.poll_ok     = (act_ff == ActReport) || ok_ff;
               rsp_data_in.out_state   = out_bit_ff;
               rsp_data_in.din_state   = din_bit_ff;
               rsp_data_in.adc_level   = level_ff;
               rsp_data_in.led_state   = led_bit_ff;
               rsp_data_in.rise_event  = flags_ff[EvRise];
               rsp_data_in.fall_event  = flags_ff[EvFall];
               rsp_data_in.on_event    = flags_ff[EvOn];
               rsp_data_in.off_event   = flags_ff[EvOff];
               rsp_data_in.adc_event   = flags_ff[EvAdc];
               rsp_data_in.first_event = flags_ff[EvFirst];
               rsp_data_in.any_event   = |flags_ff;
               if (act_ff == ActReport) begin
                  flags_in = '0;
               end
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         hyst_ff      <= HystReset;
         out_bit_ff   <= 1'b0;
         din_bit_ff   <= 1'b0;
         led_bit_ff   <= 1'b0;
         level_ff     <= 16'd0;
         flags_ff     <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_bit_ff   <= out_bit_in;
         din_bit_ff   <= din_bit_in;
         led_bit_ff   <= led_bit_in;
         level_ff     <= level_in;
         flags_ff     <= flags_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            hyst_ff <= csr_wr_data;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      ok_ff       <= ok_in;
      sample_ff   <= sample_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sim/tb_switch_status_change_tracker_core.sv @@
module tb_switch_status_change_tracker_core
   import sstc_pkg::*;
();

   localparam int CycleLimit  = 400000;
   localparam int HoldCycles  = 300;
   localparam int SettleGap   = 25;
   localparam int DrainCycles = 40;

   typedef struct {
      bit          is_cfg;
      logic [15:0] cfg_value;
      req_type     word;
      bit          has_golden;
      rsp_type     golden;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   // mirror of the tracker state and its hysteresis register
   logic [15:0]        hyst_q;
   logic               out_q;
   logic               din_q;
   logic               led_q;
   logic               first_q;
   logic [15:0]        level_q;
   logic [EvCount-1:0] flags_q;

   rsp_type      pending_q[$];
   stim_row_type dir_rows[$];
   int           errors      = 0;
   int           cycles      = 0;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   int           hold_count  = 0;

   switch_status_change_tracker_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // apply one request word to the mirror and return the response it should produce
   function automatic rsp_type advance_tracker(req_type w);
      rsp_type     r;
      logic [15:0] sample;
      logic        new_out;
      logic        new_din;
      int          s;
      int          l;
      int          hs;
      r = '0;
      r.poll_ok = 1'b1;
      if (w.action == ActPoll && !w.read_ok) begin
         r.poll_ok = 1'b0;
      end else if (w.action == ActPoll) begin
         new_out = (w.out_word == WordOne);
         new_din = (w.din_word == WordOne);
         sample  = w.adc_sample & AdcMask;
         if (din_q && !new_din) flags_q[EvFall] = 1'b1;
         if (!din_q && new_din) flags_q[EvRise] = 1'b1;
         if (out_q && !new_out) flags_q[EvOff] = 1'b1;
         if (!out_q && new_out) flags_q[EvOn] = 1'b1;
         out_q = new_out;
         din_q = new_din;
         // dead band compare is signed, so the lower edge can sit below zero
         s  = int'(sample);
         l  = int'(level_q);
         hs = int'(hyst_q);
         if (s >= l + hs || s <= l - hs) begin
            flags_q[EvAdc] = 1'b1;
            level_q = (hyst_q == 16'd0) ? sample : sample - (sample % hyst_q);
         end
         led_q = (w.led_word == WordOne);
         if (first_q) begin
            flags_q[EvFirst] = 1'b1;
            first_q = 1'b0;
         end
      end
      r.out_state   = out_q;
      r.din_state   = din_q;
      r.adc_level   = level_q;
      r.led_state   = led_q;
      r.rise_event  = flags_q[EvRise];
      r.fall_event  = flags_q[EvFall];
      r.on_event    = flags_q[EvOn];
      r.off_event   = flags_q[EvOff];
      r.adc_event   = flags_q[EvAdc];
      r.first_event = flags_q[EvFirst];
      r.any_event   = |flags_q;
      // a report clears the flags after they are returned
      if (w.action == ActReport) flags_q = '0;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   task automatic compare_rsp(rsp_type want, rsp_type got);
      check_field("poll_ok", 16'(want.poll_ok), 16'(got.poll_ok));
      check_field("out_state", 16'(want.out_state), 16'(got.out_state));
      check_field("din_state", 16'(want.din_state), 16'(got.din_state));
      check_field("adc_level", want.adc_level, got.adc_level);
      check_field("led_state", 16'(want.led_state), 16'(got.led_state));
      check_field("rise_event", 16'(want.rise_event), 16'(got.rise_event));
      check_field("fall_event", 16'(want.fall_event), 16'(got.fall_event));
      check_field("on_event", 16'(want.on_event), 16'(got.on_event));
      check_field("off_event", 16'(want.off_event), 16'(got.off_event));
      check_field("adc_event", 16'(want.adc_event), 16'(got.adc_event));
      check_field("first_event", 16'(want.first_event), 16'(got.first_event));
      check_field("any_event", 16'(want.any_event), 16'(got.any_event));
   endtask

   // check every response word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $error("response word with no expectation pending");
            errors++;
         end else begin
            compare_rsp(pending_q.pop_front(), rsp_data);
         end
      end
   end

   // drive rsp_ready; a new hold request stalls it for a long stretch
   initial begin
      int seen_hold;
      int hold_left;
      seen_hold = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_count != seen_hold) begin
            seen_hold = hold_count;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic stim_row_type poll_row(logic ok, logic [15:0] o, logic [15:0] d,
                                             logic [15:0] a, logic [15:0] l);
      stim_row_type r;
      r.is_cfg          = 1'b0;
      r.cfg_value       = '0;
      r.word.action     = ActPoll;
      r.word.read_ok    = ok;
      r.word.out_word   = o;
      r.word.din_word   = d;
      r.word.adc_sample = a;
      r.word.led_word   = l;
      r.has_golden      = 1'b0;
      r.golden          = '0;
      return r;
   endfunction

   function automatic stim_row_type report_row(logic ok, logic [15:0] junk);
      stim_row_type r;
      r = poll_row(ok, junk, junk, junk, junk);
      r.word.action = ActReport;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(logic [15:0] v);
      stim_row_type r;
      r = poll_row(1'b0, '0, '0, '0, '0);
      r.is_cfg    = 1'b1;
      r.cfg_value = v;
      return r;
   endfunction

   function automatic stim_row_type with_golden(stim_row_type r, rsp_type g);
      stim_row_type t;
      t = r;
      t.has_golden = 1'b1;
      t.golden     = g;
      return t;
   endfunction

   // register words: mostly exact 0 or 1, some near misses and arbitrary values
   function automatic logic [15:0] flag_word();
      case ($urandom_range(9))
         0, 1, 2, 3: return WordOne;
         4, 5, 6:    return 16'd0;
         7:          return 16'hFFFF;
         8:          return WordOne ^ (16'd1 << $urandom_range(15));
         default:    return 16'($urandom);
      endcase
   endfunction

   // ADC samples clustered on the dead band edges around the stored level
   function automatic logic [15:0] adc_pick();
      int base;
      int h;
      base = int'(level_q);
      h    = int'(hyst_q);
      case ($urandom_range(7))
         0, 1:    return 16'($urandom);
         2:       return 16'(base + h + int'($urandom_range(2)) - 1);
         3:       return 16'(base - h + int'($urandom_range(2)) - 1);
         4:       return 16'(base - h + 1 + int'($urandom_range(hyst_q)));
         5:       return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
         default: return 16'(base + int'($urandom_range(3 * hyst_q)) - h);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.action     = ($urandom_range(99) < 18) ? ActReport : ActPoll;
      w.read_ok    = ($urandom_range(99) < 88);
      w.out_word   = flag_word();
      w.din_word   = flag_word();
      w.adc_sample = adc_pick();
      w.led_word   = flag_word();
      return w;
   endfunction

   // offer one word after a random gap, record its response once accepted
   task automatic send_word(req_type w, bit has_golden, rsp_type golden);
      rsp_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predicted = advance_tracker(w);
      pending_q.push_back(has_golden ? golden : predicted);
   endtask

   // write the hysteresis register once the block has drained
   task automatic write_hyst(logic [15:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SettleGap) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      hyst_q = v;
   endtask

   task automatic run_segment(logic [15:0] hyst, int tx_pct, int rx_pct, bit hold, int items);
      write_hyst(hyst);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      if (hold) hold_count++;
      repeat (items) send_word(random_word(), 1'b0, '0);
   endtask

   initial begin
      rsp_type nothing_yet;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      hyst_q      = HystReset;
      out_q       = 1'b0;
      din_q       = 1'b0;
      led_q       = 1'b0;
      first_q     = 1'b1;
      level_q     = '0;
      flags_q     = '0;
      nothing_yet = '0;
      nothing_yet.poll_ok = 1'b1;

      // directed table; hysteresis starts at its reset value
      dir_rows.push_back(with_golden(report_row(1'b0, 16'h0000), nothing_yet));
      dir_rows.push_back(with_golden(poll_row(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                     '0));
      dir_rows.push_back(with_golden(report_row(1'b0, 16'hFFFF), nothing_yet));
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd1, 16'hFFFF, 16'd1));
      dir_rows.push_back(report_row(1'b1, 16'h5A5A));
      dir_rows.push_back(poll_row(1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
      dir_rows.push_back(poll_row(1'b1, 16'd2, 16'h8001, 16'd4, 16'hFFFF));
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd0, 16'd5, 16'd1));
      dir_rows.push_back(poll_row(1'b1, 16'd0, 16'd1, 16'd1, 16'd0));
      dir_rows.push_back(poll_row(1'b1, 16'd0, 16'd1, 16'd0, 16'd0));
      // lower band edge below zero: sample 0 must not move the level
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd1, 16'd0, 16'd1));
      dir_rows.push_back(poll_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 16'd0));
      dir_rows.push_back(report_row(1'b0, 16'hFFFF));
      // zero hysteresis: every good poll moves the level, unquantized
      dir_rows.push_back(cfg_row(16'd0));
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd0, 16'd12345, 16'd0));
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd0, 16'd12345, 16'd0));
      dir_rows.push_back(report_row(1'b1, 16'h0000));
      dir_rows.push_back(cfg_row(16'hFFFF));
      dir_rows.push_back(poll_row(1'b1, 16'd0, 16'd1, 16'hFFFE, 16'd1));
      dir_rows.push_back(poll_row(1'b1, 16'd0, 16'd1, 16'd0, 16'd1));
      dir_rows.push_back(cfg_row(16'd1));
      dir_rows.push_back(poll_row(1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
      dir_rows.push_back(cfg_row(16'hFFFF));
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd1, 16'hFFFF, 16'd1));
      dir_rows.push_back(poll_row(1'b1, 16'd1, 16'd1, 16'd0, 16'd1));
      dir_rows.push_back(report_row(1'b0, 16'h1234));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].is_cfg) begin
            write_hyst(dir_rows[i].cfg_value);
         end else begin
            send_word(dir_rows[i].word, dir_rows[i].has_golden, dir_rows[i].golden);
         end
      end

      // random traffic: receiver sparse, then sender sparse, then full rate
      run_segment(HystReset, 12, 86, 1'b0, 67);
      run_segment(16'd1, 12, 86, 1'b0, 67);
      run_segment(16'd300, 86, 12, 1'b0, 67);
      run_segment(16'hFFFF, 86, 12, 1'b0, 67);
      run_segment(16'd37, 0, 0, 1'b1, 67);
      run_segment(16'($urandom_range(65534, 2)), 0, 0, 1'b0, 67);

      // drain and report
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
